FILE: hw/rtl/cnes_pkg.sv
// Shared types, widths and constants of the chord note event scheduler.
package cnes_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int NOTE_IN_W = 8;
    localparam int NOTE_W    = 7;
    localparam int CHAN_W    = 5;
    localparam int VEL_W     = 7;
    localparam int MS_W      = 16;
    localparam int BLOCK_W   = 16;
    localparam int OFFSET_W  = 16;
    localparam int RATE_W    = 19;
    localparam int LEN_W     = 25;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_VELOCITY = 2'd2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_NOTE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALL_OFF = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RENDER  = 2'd2;

    // Defaults and limits
    localparam int MAX_NOTES_DEF = 16;
    localparam logic [RATE_W-1:0]    RATE_DEFAULT = 19'd44100;
    localparam logic [CHAN_W-1:0]    CHAN_RESET   = 5'd1;
    localparam logic [VEL_W-1:0]     VEL_RESET    = 7'd100;
    localparam logic [NOTE_IN_W-1:0] NOTE_MAX     = 8'd127;
    localparam logic [LEN_W-1:0]     LENGTH_MAX   = 25'h1FF_FFFF;

    // Chord length arithmetic: (rate * ms + 500) / 1000 as (x >> 3) / 125,
    // the divide by 125 done as a multiply by ceil(2^35 / 125) and a shift by 35,
    // exact for every dividend below 2^35
    localparam int DVD_W       = RATE_W + MS_W;
    localparam int QUO_W       = LEN_W + 1;
    localparam int PRE_SHIFT   = 3;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 35;
    localparam int PROD_W      = DVD_W - PRE_SHIFT + RECIP_W;
    localparam logic [DVD_W-1:0]   ROUND_BIAS = DVD_W'(500);
    localparam logic [RECIP_W-1:0] RECIP_M    = 29'h1062_4DD3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_OFF,
        ST_ON,
        ST_HOLD,
        ST_REL,
        ST_DRAIN
    } sched_state_t;

    typedef enum logic [1:0] {
        LEN_IDLE,
        LEN_MUL,
        LEN_BIAS,
        LEN_DIV
    } len_state_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] length;
    } len_result_t;

endpackage

FILE: hw/rtl/cnes_ifs.sv
// Request and event channel interfaces of the chord note event scheduler.
interface cnes_item_if;
    import cnes_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [NOTE_IN_W-1:0] note;
    logic                 first_of_chord;
    logic                 last_of_chord;
    logic [MS_W-1:0]      duration_ms;
    logic [BLOCK_W-1:0]   block_samples;

    modport source (
        output valid, cmd, note, first_of_chord, last_of_chord, duration_ms, block_samples,
        input  ready
    );

    modport sink (
        input  valid, cmd, note, first_of_chord, last_of_chord, duration_ms, block_samples,
        output ready
    );
endinterface

interface cnes_event_if;
    import cnes_pkg::*;

    logic                valid;
    logic                ready;
    logic                is_note_on;
    logic [NOTE_W-1:0]   event_note;
    logic [CHAN_W-1:0]   event_channel;
    logic [VEL_W-1:0]    event_velocity;
    logic [OFFSET_W-1:0] sample_offset;
    logic                last_event;

    modport source (
        output valid, is_note_on, event_note, event_channel, event_velocity,
               sample_offset, last_event,
        input  ready
    );

    modport sink (
        input  valid, is_note_on, event_note, event_channel, event_velocity,
               sample_offset, last_event,
        output ready
    );
endinterface

FILE: hw/rtl/cnes_note_mem.sv
// Note store: one write port, one read port with registered read data.
module cnes_note_mem #(
    parameter int DEPTH  = cnes_pkg::MAX_NOTES_DEF,
    parameter int WIDTH  = cnes_pkg::NOTE_W,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/cnes_len_unit.sv
// Chord length unit: rate times duration, rounded divide by 1000, clamped.
module cnes_len_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cnes_pkg::RATE_W-1:0]   sample_rate,
    input  logic [cnes_pkg::MS_W-1:0]     duration_ms,
    output cnes_pkg::len_result_t         result
);
    import cnes_pkg::*;

    len_state_t state_reg, state_next;

    logic [RATE_W-1:0] rate_reg;
    logic [MS_W-1:0]   ms_reg;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic              done_reg, done_next;

    logic              load_op;
    logic              mul_en;
    logic              bias_en;
    logic              div_en;
    logic [PROD_W-1:0] recip_prod;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            LEN_IDLE: if (start) state_next = LEN_MUL;
            LEN_MUL:  state_next = LEN_BIAS;
            LEN_BIAS: state_next = LEN_DIV;
            LEN_DIV:  state_next = LEN_IDLE;
            default:  state_next = LEN_IDLE;
        endcase
    end

    // Step enables
    always_comb
    begin
        load_op = 1'b0;
        mul_en  = 1'b0;
        bias_en = 1'b0;
        div_en  = 1'b0;
        unique case (state_reg)
            LEN_IDLE: load_op = start;
            LEN_MUL:  mul_en  = 1'b1;
            LEN_BIAS: bias_en = 1'b1;
            LEN_DIV:  div_en  = 1'b1;
            default:  load_op = 1'b0;
        endcase
    end

    // Multiply, add the rounding bias, then divide by 1000 through the reciprocal
    always_comb
    begin
        recip_prod = PROD_W'(dvd_reg[DVD_W-1:PRE_SHIFT]) * PROD_W'(RECIP_M);

        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        priority if (mul_en)
        begin
            dvd_next = DVD_W'(rate_reg) * DVD_W'(ms_reg);
        end
        else if (bias_en)
        begin
            dvd_next = dvd_reg + ROUND_BIAS;
        end
        else if (div_en)
        begin
            quo_next  = recip_prod[RECIP_SHIFT +: QUO_W];
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LEN_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Capture operands, zero rate and zero duration replaced
    always_ff @(posedge clk)
    begin
        if (load_op)
        begin
            rate_reg <= (sample_rate == '0) ? RATE_DEFAULT : sample_rate;
            ms_reg   <= (duration_ms == '0) ? MS_W'(1) : duration_ms;
        end
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    // Clamp to one sample at least and to the counter range
    always_comb
    begin
        result.done = done_reg;
        priority if (quo_reg == '0)
            result.length = LEN_W'(1);
        else if (quo_reg[QUO_W-1])
            result.length = LENGTH_MAX;
        else
            result.length = quo_reg[LEN_W-1:0];
    end

`ifndef SYNTH
    a_len_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.done |-> (result.length != '0))
        else $error("chord length of zero");

    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        result.done |-> ($past(state_reg) == LEN_DIV))
        else $error("length done without a divide");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg != LEN_IDLE) |-> 1'b0)
        else $error("length start while busy");
`endif

endmodule

FILE: hw/rtl/chord_note_event_scheduler.sv
// Chord note event scheduler: stages chords from note requests and emits MIDI
// note-on and note-off events for each render block. The note request that
// closes a chord waits for the chord length unit (one multiply, a rounding add,
// then a divide by 1000 as a reciprocal multiply, and a register to hand the
// length back). A render request with events streams them at one per cycle
// while the event side keeps taking, pausing when the chord's note-offs follow
// its note-ons in the same block: the note stores have one read port each with
// registered read data, and the block waits for the last event to leave its
// holding stage before taking the next request.
module chord_note_event_scheduler #(
    parameter int MAX_NOTES = cnes_pkg::MAX_NOTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    cnes_item_if.sink                         items,
    cnes_event_if.source                      events,
    input  logic                              cfg_we,
    input  logic [cnes_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cnes_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cnes_pkg::*;

    localparam int CNT_W = $clog2(MAX_NOTES + 1);
    localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int EVT_W = $clog2(3 * MAX_NOTES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_NOTES);

    // Configuration registers
    logic [RATE_W-1:0] sample_rate_reg;
    logic [CHAN_W-1:0] midi_channel_reg;
    logic [VEL_W-1:0]  note_velocity_reg;

    // Scalar scheduler state
    logic [CNT_W-1:0]  staged_count_reg, staged_count_next;
    logic              staged_all_off_reg, staged_all_off_next;
    logic [LEN_W-1:0]  staged_length_reg, staged_length_next;
    logic              request_waiting_reg, request_waiting_next;
    logic [CNT_W-1:0]  sounding_count_reg, sounding_count_next;
    logic              release_armed_reg, release_armed_next;
    logic [LEN_W-1:0]  samples_left_reg, samples_left_next;

    // Render sequencing
    sched_state_t      state_reg, state_next;
    logic [CNT_W-1:0]  off_cnt_reg, on_cnt_reg, rel_cnt_reg;
    logic [OFFSET_W-1:0] rel_off_reg;
    logic [EVT_W-1:0]  evt_left_reg, evt_left_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    // Holding stage between memory read and output register
    logic              pend_valid_reg;
    logic              pend_on_reg;
    logic              pend_last_reg;
    logic [OFFSET_W-1:0] pend_off_reg;
    logic [IDX_W-1:0]  pend_idx_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_on_reg;
    logic [NOTE_W-1:0] out_note_reg;
    logic [CHAN_W-1:0] out_chan_reg;
    logic [VEL_W-1:0]  out_vel_reg;
    logic [OFFSET_W-1:0] out_off_reg;
    logic              out_last_reg;

    // Control
    logic              accept;
    logic              acc_note;
    logic              acc_off;
    logic              acc_render;
    logic              emit;
    logic              issue;
    logic              pend_move;
    logic [CNT_W-1:0]  phase_cnt;
    logic              phase_end;
    logic              stg_re;
    logic              snd_re;
    logic              len_start;
    len_result_t       len_res;

    // Staging of a note
    logic [CNT_W-1:0]  base_cnt;
    logic              stage_ok;
    logic              stg_we;

    // Render plan
    logic              on_go;
    logic [CNT_W-1:0]  off_n, on_n, rel_n, cnt1;
    logic              armed1;
    logic [LEN_W-1:0]  left1, block_ext, left_sub, left_dec;
    logic              fire;
    logic [EVT_W-1:0]  total;
    sched_state_t      start_state;

    logic [NOTE_W-1:0] stg_rdata;
    logic [NOTE_W-1:0] snd_rdata;
    logic [NOTE_W-1:0] pend_note;

    assign accept     = items.valid && items.ready;
    assign acc_note   = accept && (items.cmd == CMD_NOTE);
    assign acc_off    = accept && (items.cmd == CMD_ALL_OFF);
    assign acc_render = accept && (items.cmd == CMD_RENDER);
    assign pend_move  = pend_valid_reg && (!out_valid_reg || events.ready);
    assign len_start  = acc_note && items.last_of_chord;

    // Note staging slot
    always_comb
    begin
        base_cnt = items.first_of_chord ? '0 : staged_count_reg;
        stage_ok = (items.note <= NOTE_MAX) && (base_cnt < CNT_FULL);
        stg_we   = acc_note && stage_ok;
    end

    // Plan a render block from the current state
    always_comb
    begin
        on_go     = request_waiting_reg && !staged_all_off_reg && (staged_count_reg != '0);
        off_n     = request_waiting_reg ? sounding_count_reg : '0;
        on_n      = on_go ? staged_count_reg : '0;
        block_ext = LEN_W'(items.block_samples);
        priority if (on_go)
        begin
            cnt1   = staged_count_reg;
            armed1 = 1'b1;
            left1  = staged_length_reg;
        end
        else if (request_waiting_reg)
        begin
            cnt1   = '0;
            armed1 = 1'b0;
            left1  = '0;
        end
        else
        begin
            cnt1   = sounding_count_reg;
            armed1 = release_armed_reg;
            left1  = samples_left_reg;
        end
        fire     = armed1 && (cnt1 != '0) && (left1 <= block_ext);
        rel_n    = fire ? cnt1 : '0;
        left_sub = left1 - block_ext;
        left_dec = (left1 != '0) ? (left1 - LEN_W'(1)) : '0;
        total    = EVT_W'(off_n) + EVT_W'(on_n) + EVT_W'(rel_n);
        priority if (off_n != '0)
            start_state = ST_OFF;
        else if (on_n != '0)
            start_state = ST_ON;
        else if (rel_n != '0)
            start_state = ST_REL;
        else
            start_state = ST_IDLE;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                priority if (len_start)
                    state_next = ST_LEN;
                else if (acc_render)
                    state_next = start_state;
            end
            ST_LEN:   if (len_res.done) state_next = ST_IDLE;
            ST_OFF:   if (phase_end) state_next = (on_cnt_reg != '0) ? ST_ON : ST_DRAIN;
            ST_ON:    if (phase_end) state_next = (rel_cnt_reg != '0) ? ST_HOLD : ST_DRAIN;
            ST_HOLD:  if (!pend_valid_reg) state_next = ST_REL;
            ST_REL:   if (phase_end) state_next = ST_DRAIN;
            ST_DRAIN: if (!pend_valid_reg) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // State outputs: request ready, memory reads, phase length
    always_comb
    begin
        items.ready = 1'b0;
        emit        = 1'b0;
        stg_re      = 1'b0;
        snd_re      = 1'b0;
        phase_cnt   = '0;
        unique case (state_reg)
            ST_IDLE: items.ready = 1'b1;
            ST_OFF:
            begin
                emit      = 1'b1;
                phase_cnt = off_cnt_reg;
            end
            ST_ON:
            begin
                emit      = 1'b1;
                phase_cnt = on_cnt_reg;
            end
            ST_REL:
            begin
                emit      = 1'b1;
                phase_cnt = rel_cnt_reg;
            end
            ST_LEN, ST_HOLD, ST_DRAIN: emit = 1'b0;
            default: emit = 1'b0;
        endcase
        issue     = emit && (!pend_valid_reg || pend_move);
        phase_end = issue && ((idx_reg + CNT_W'(1)) == phase_cnt);
        stg_re    = issue && (state_reg == ST_ON);
        snd_re    = issue && (state_reg != ST_ON);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg   <= RATE_DEFAULT;
            midi_channel_reg  <= CHAN_RESET;
            note_velocity_reg <= VEL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SAMPLE_RATE:   sample_rate_reg   <= cfg_data[RATE_W-1:0];
                CFG_MIDI_CHANNEL:  midi_channel_reg  <= cfg_data[CHAN_W-1:0];
                CFG_NOTE_VELOCITY: note_velocity_reg <= cfg_data[VEL_W-1:0];
                default:           sample_rate_reg   <= sample_rate_reg;
            endcase
        end
    end

    // Staging and sounding state updates
    always_comb
    begin
        staged_count_next    = staged_count_reg;
        staged_all_off_next  = staged_all_off_reg;
        staged_length_next   = staged_length_reg;
        request_waiting_next = request_waiting_reg;
        sounding_count_next  = sounding_count_reg;
        release_armed_next   = release_armed_reg;
        samples_left_next    = samples_left_reg;
        if (acc_note)
        begin
            staged_count_next = stage_ok ? (base_cnt + CNT_W'(1)) : base_cnt;
            if (items.last_of_chord)
            begin
                staged_all_off_next  = 1'b0;
                request_waiting_next = 1'b1;
            end
        end
        if (acc_off)
        begin
            staged_all_off_next  = 1'b1;
            staged_count_next    = '0;
            staged_length_next   = '0;
            request_waiting_next = 1'b1;
        end
        if (len_res.done)
        begin
            staged_length_next = len_res.length;
        end
        if (acc_render)
        begin
            request_waiting_next = 1'b0;
            if (fire)
            begin
                sounding_count_next = '0;
                release_armed_next  = 1'b0;
                samples_left_next   = '0;
            end
            else
            begin
                sounding_count_next = cnt1;
                release_armed_next  = armed1;
                samples_left_next   = (armed1 && (cnt1 != '0)) ? left_sub : left1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            staged_count_reg    <= '0;
            staged_all_off_reg  <= 1'b0;
            staged_length_reg   <= '0;
            request_waiting_reg <= 1'b0;
            sounding_count_reg  <= '0;
            release_armed_reg   <= 1'b0;
            samples_left_reg    <= '0;
        end
        else
        begin
            staged_count_reg    <= staged_count_next;
            staged_all_off_reg  <= staged_all_off_next;
            staged_length_reg   <= staged_length_next;
            request_waiting_reg <= request_waiting_next;
            sounding_count_reg  <= sounding_count_next;
            release_armed_reg   <= release_armed_next;
            samples_left_reg    <= samples_left_next;
        end
    end

    // Sequencer counters
    always_comb
    begin
        evt_left_next = evt_left_reg;
        idx_next      = idx_reg;
        if (acc_render)
        begin
            evt_left_next = total;
            idx_next      = '0;
        end
        else if (issue)
        begin
            evt_left_next = evt_left_reg - EVT_W'(1);
            idx_next      = phase_end ? '0 : (idx_reg + CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            evt_left_reg   <= '0;
            idx_reg        <= '0;
            off_cnt_reg    <= '0;
            on_cnt_reg     <= '0;
            rel_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            evt_left_reg <= evt_left_next;
            idx_reg      <= idx_next;
            if (acc_render)
            begin
                off_cnt_reg <= off_n;
                on_cnt_reg  <= on_n;
                rel_cnt_reg <= rel_n;
            end
            // Hold stage fills on a read and empties into the output register
            if (issue)
                pend_valid_reg <= 1'b1;
            else if (pend_move)
                pend_valid_reg <= 1'b0;
            if (pend_move)
                out_valid_reg <= 1'b1;
            else if (events.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Release offset and holding stage payload
    always_ff @(posedge clk)
    begin
        if (acc_render)
        begin
            rel_off_reg <= left_dec[OFFSET_W-1:0];
        end
        if (issue)
        begin
            pend_on_reg   <= (state_reg == ST_ON);
            pend_last_reg <= (evt_left_reg == EVT_W'(1));
            pend_off_reg  <= (state_reg == ST_REL) ? rel_off_reg : '0;
            pend_idx_reg  <= idx_reg[IDX_W-1:0];
        end
    end

    assign pend_note = pend_on_reg ? stg_rdata : snd_rdata;

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (pend_move)
        begin
            out_on_reg   <= pend_on_reg;
            out_note_reg <= pend_note;
            out_chan_reg <= midi_channel_reg;
            out_vel_reg  <= pend_on_reg ? note_velocity_reg : '0;
            out_off_reg  <= pend_off_reg;
            out_last_reg <= pend_last_reg;
        end
    end

    assign events.valid          = out_valid_reg;
    assign events.is_note_on     = out_on_reg;
    assign events.event_note     = out_note_reg;
    assign events.event_channel  = out_chan_reg;
    assign events.event_velocity = out_vel_reg;
    assign events.sample_offset  = out_off_reg;
    assign events.last_event     = out_last_reg;

    // Staged chord notes: written by note requests, read for note-ons
    cnes_note_mem #(
        .DEPTH  (MAX_NOTES),
        .WIDTH  (NOTE_W),
        .ADDR_W (IDX_W)
    ) u_staged_mem (
        .clk   (clk),
        .we    (stg_we),
        .waddr (base_cnt[IDX_W-1:0]),
        .wdata (items.note[NOTE_W-1:0]),
        .re    (stg_re),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (stg_rdata)
    );

    // Sounding notes: copied from staging as each note-on leaves the hold stage
    cnes_note_mem #(
        .DEPTH  (MAX_NOTES),
        .WIDTH  (NOTE_W),
        .ADDR_W (IDX_W)
    ) u_sounding_mem (
        .clk   (clk),
        .we    (pend_move && pend_on_reg),
        .waddr (pend_idx_reg),
        .wdata (stg_rdata),
        .re    (snd_re),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (snd_rdata)
    );

    cnes_len_unit u_len (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (len_start),
        .sample_rate (sample_rate_reg),
        .duration_ms (items.duration_ms),
        .result      (len_res)
    );

`ifndef SYNTH
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!pend_valid_reg && evt_left_reg == '0))
        else $error("idle with events still in flight");

    a_issue_budget: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (evt_left_reg != '0))
        else $error("memory read beyond the planned events");

    a_counts_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (staged_count_reg <= CNT_FULL) && (sounding_count_reg <= CNT_FULL))
        else $error("note count above store depth");

    a_len_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        len_res.done |-> (state_reg == ST_LEN))
        else $error("chord length arrived outside its wait");

    a_rel_after_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REL && $past(state_reg) != ST_REL) |-> !$past(pend_valid_reg))
        else $error("release read may overlap a sounding write");
`endif

endmodule
